[design/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: assertion failed");

// When the antecedent holds, the consequent must hold on the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

[design/imm_pkg.sv]
// -----------------------------------------------------------------------------
// imm_pkg
// Types, constants and helpers shared by the matrix multiply core.
// -----------------------------------------------------------------------------
package imm_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	localparam int DIM_W      = 4;
	localparam int ROWCOL_W   = 3;
	localparam int IN_VALUE_W = 16;
	localparam int VALUE_W    = 32;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

	typedef struct packed {
		logic                wr_a;
		logic                wr_b;
		logic                rd_en;
		logic                first;
		logic                last_k;
		logic [ROWCOL_W-1:0] row_i;
		logic [ROWCOL_W-1:0] col_j;
		logic [ROWCOL_W-1:0] k;
		logic                out_load;
		logic                out_last;
	} imm_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} imm_status_t;

	// Highest index in use for a dimension register, with the dimension clamped to 1..max_dim.
	function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] dim,
			input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] lim;
		if (dim == '0) begin
			lim = '0;
		end else if (dim > max_dim) begin
			lim = max_dim - 1'b1;
		end else begin
			lim = dim - 1'b1;
		end
		return lim;
	endfunction

endpackage

[design/imm_datapath.sv]
// -----------------------------------------------------------------------------
// imm_datapath
// Element stores, multiply-accumulate pipeline and the result register.
// -----------------------------------------------------------------------------
module imm_datapath import imm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  imm_cmd_t                      cmd,
	output imm_status_t                   status,
	input  logic [ROWCOL_W-1:0]           elem_row,
	input  logic [ROWCOL_W-1:0]           elem_col,
	input  logic signed [IN_VALUE_W-1:0]  elem_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ROWCOL_W-1:0]           prod_row,
	output logic [ROWCOL_W-1:0]           prod_col,
	output logic signed [VALUE_W-1:0]     prod_value,
	output logic                          last
);

	localparam int IW    = $clog2(MAX_DIM);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;

	logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr_a;
	logic [AW-1:0]                rd_addr_b;
	logic signed [ELEM_WIDTH-1:0] wr_data;

	logic signed [ELEM_WIDTH-1:0] a_s1;
	logic signed [ELEM_WIDTH-1:0] b_s1;
	logic                         valid_s1;
	logic                         first_s1;
	logic                         last_k_s1;

	logic signed [VALUE_W-1:0]    a_ext;
	logic signed [VALUE_W-1:0]    b_ext;
	logic signed [VALUE_W-1:0]    prod_s2;
	logic                         valid_s2;
	logic                         first_s2;
	logic                         last_k_s2;

	logic signed [VALUE_W-1:0]    acc_q;
	logic                         done_q;
	logic                         out_valid_q;

	assign wr_addr   = {elem_row[IW-1:0], elem_col[IW-1:0]};
	assign rd_addr_a = {cmd.row_i[IW-1:0], cmd.k[IW-1:0]};
	assign rd_addr_b = {cmd.k[IW-1:0], cmd.col_j[IW-1:0]};
	assign wr_data   = ELEM_WIDTH'(elem_value);

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			a_s1 <= mem_a[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b) begin
			mem_b[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	assign a_ext = VALUE_W'(a_s1);
	assign b_ext = VALUE_W'(b_s1);

	always_ff @(posedge clk) begin
		first_s1  <= cmd.first;
		last_k_s1 <= cmd.last_k;
		prod_s2   <= a_ext * b_ext;
		first_s2  <= first_s1;
		last_k_s2 <= last_k_s1;
		if (valid_s2) begin
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
		end
		if (cmd.out_load) begin
			prod_row   <= cmd.row_i;
			prod_col   <= cmd.col_j;
			prod_value <= acc_q;
			last       <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			if (cmd.out_load) begin
				done_q <= 1'b0;
			end else if (valid_s2 && last_k_s2) begin
				done_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status.done     = done_q;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

[design/imm_controller.sv]
// -----------------------------------------------------------------------------
// imm_controller
// Dimension registers, load decode and the sequencer that walks the product.
// -----------------------------------------------------------------------------
module imm_controller import imm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ROWCOL_W-1:0]   elem_row,
	input  logic [ROWCOL_W-1:0]   elem_col,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DIM_W-1:0]      cfg_data,
	output imm_cmd_t              cmd,
	input  imm_status_t           status
);

	localparam int IW = $clog2(MAX_DIM);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]       state_q;
	logic [DIM_W-1:0] rows_a_q;
	logic [DIM_W-1:0] inner_dim_q;
	logic [DIM_W-1:0] cols_b_q;
	logic [IW-1:0]    i_q;
	logic [IW-1:0]    j_q;
	logic [IW-1:0]    k_q;
	logic [IW-1:0]    i_lim_q;
	logic [IW-1:0]    k_lim_q;
	logic [IW-1:0]    j_lim_q;

	logic             in_beat;
	logic             in_range;
	logic             last_k;
	logic             last_elem;
	logic             load_out;
	logic [DIM_W-1:0] i_lim;
	logic [DIM_W-1:0] k_lim;
	logic [DIM_W-1:0] j_lim;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_beat   = in_valid && !in_stall;
	assign in_range  = (DIM_W'(elem_row) < DIM_W'(MAX_DIM)) &&
		(DIM_W'(elem_col) < DIM_W'(MAX_DIM));

	assign i_lim = dim_limit(rows_a_q, DIM_W'(MAX_DIM));
	assign k_lim = dim_limit(inner_dim_q, DIM_W'(MAX_DIM));
	assign j_lim = dim_limit(cols_b_q, DIM_W'(MAX_DIM));

	assign last_k    = (k_q == k_lim_q);
	assign last_elem = (i_q == i_lim_q) && (j_q == j_lim_q);
	assign load_out  = (state_q == ST_WAIT) && status.done && status.out_free;

	always_comb begin
		cmd          = '0;
		cmd.wr_a     = in_beat && (req_type == REQ_LOAD_A) && in_range;
		cmd.wr_b     = in_beat && (req_type == REQ_LOAD_B) && in_range;
		cmd.rd_en    = (state_q == ST_RUN);
		cmd.first    = (k_q == '0);
		cmd.last_k   = last_k;
		cmd.row_i    = ROWCOL_W'(i_q);
		cmd.col_j    = ROWCOL_W'(j_q);
		cmd.k        = ROWCOL_W'(k_q);
		cmd.out_load = load_out;
		cmd.out_last = last_elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROWS_A:    rows_a_q    <= cfg_data;
				CFG_INNER_DIM: inner_dim_q <= cfg_data;
				CFG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			i_lim_q <= '0;
			k_lim_q <= '0;
			j_lim_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && (req_type == REQ_START)) begin
						i_lim_q <= i_lim[IW-1:0];
						k_lim_q <= k_lim[IW-1:0];
						j_lim_q <= j_lim[IW-1:0];
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (load_out) begin
						if (last_elem) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							if (j_q == j_lim_q) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/integer_matrix_multiply_core.sv]
// -----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Signed integer matrix multiplier with on-chip element stores.
// -----------------------------------------------------------------------------
// The input channel carries load and start beats. A load beat writes one
// element of A or B, so loads stream at one beat per cycle while the block
// is idle. A load whose row or column is not below MAX_DIM is dropped. A
// start beat walks the product in row-major order; for each product element
// both stores are read once per inner index, and each pair passes through
// the read and product registers into the accumulator, whose sum then goes
// to the output register. The input stalls from the start beat until the
// final element is in the output register. The output channel presents one
// element per beat with its row and column, and last marks the final
// element. A stall on the output holds the element; the walk goes on to
// accumulate the next one but waits before loading it. The configuration
// channel is always ready and sets rows_a, inner_dim and cols_b; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Reset sets all three dimensions to eight and empties the
// pipeline; store contents are undefined until written.
// -----------------------------------------------------------------------------
module integer_matrix_multiply_core import imm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [REQ_W-1:0]             req_type,
	input  logic [ROWCOL_W-1:0]          elem_row,
	input  logic [ROWCOL_W-1:0]          elem_col,
	input  logic signed [IN_VALUE_W-1:0] elem_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ROWCOL_W-1:0]          prod_row,
	output logic [ROWCOL_W-1:0]          prod_col,
	output logic signed [VALUE_W-1:0]    prod_value,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [DIM_W-1:0]             cfg_data
);

	imm_cmd_t    cmd;
	imm_status_t status;

	imm_controller #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.elem_row  (elem_row),
		.elem_col  (elem_col),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

	imm_datapath #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.elem_row   (elem_row),
		.elem_col   (elem_col),
		.elem_value (elem_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.prod_row   (prod_row),
		.prod_col   (prod_col),
		.prod_value (prod_value),
		.last       (last)
	);

endmodule

[design/imm_checker.sv]
// -----------------------------------------------------------------------------
// imm_checker
// Port-level checks on the matrix multiply core, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module imm_checker import imm_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [REQ_W-1:0]             req_type,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [ROWCOL_W-1:0]          prod_row,
	input logic [ROWCOL_W-1:0]          prod_col,
	input logic signed [VALUE_W-1:0]    prod_value,
	input logic                         last
);

	// A stalled result beat holds its value.
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(prod_value) && $stable(prod_row) && $stable(prod_col))

	// A start beat makes the block busy on the next cycle.
	`ASSERT_NEXT(a_start_busy, in_valid && !in_stall && (req_type == REQ_START), in_stall)

	// While an element other than the final one is shown, the walk is still running.
	`ASSERT_ALWAYS(a_mid_busy, !(out_valid && !last) || in_stall)

	// Once the final element is taken, no further element follows at once.
	`ASSERT_NEXT(a_last_gap, out_valid && last && !out_stall, !out_valid)

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (.*);

[tb/tb_integer_matrix_multiply_core.sv]
// -----------------------------------------------------------------------------
// tb_integer_matrix_multiply_core
// Self-checking testbench for the integer matrix multiply core.
// -----------------------------------------------------------------------------
// Element loads and start beats are driven into the core while a local copy of
// both matrix stores and the three dimension registers works out every product
// element that each start should produce. Each output beat is compared field by
// field with the oldest outstanding element. A directed part covers the reset
// dimensions, clamped dimension values, extreme element values, wrap of the
// sums and the unused request code; random traffic then follows with sender
// gaps and receiver stalls in several mixes. Every start only reads entries
// that have been loaded.
// -----------------------------------------------------------------------------
module tb_integer_matrix_multiply_core;
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	localparam int CELLS         = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int HANG_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [ROWCOL_W-1:0]       row;
		logic [ROWCOL_W-1:0]       col;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} product_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic [REQ_W-1:0]             req_type   = '0;
	logic [ROWCOL_W-1:0]          elem_row   = '0;
	logic [ROWCOL_W-1:0]          elem_col   = '0;
	logic signed [IN_VALUE_W-1:0] elem_value = '0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic [ROWCOL_W-1:0]          prod_row;
	logic [ROWCOL_W-1:0]          prod_col;
	logic signed [VALUE_W-1:0]    prod_value;
	logic                         last;
	logic                         cfg_valid  = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index  = '0;
	logic [DIM_W-1:0]             cfg_data   = '0;

	logic signed [IN_VALUE_W-1:0] mat_a [CELLS];
	logic signed [IN_VALUE_W-1:0] mat_b [CELLS];
	bit                           loaded_a [CELLS];
	bit                           loaded_b [CELLS];
	logic [DIM_W-1:0]             dim_rows  = DIM_RESET;
	logic [DIM_W-1:0]             dim_inner = DIM_RESET;
	logic [DIM_W-1:0]             dim_cols  = DIM_RESET;

	product_t pending_products [$];
	product_t head_product;
	int       mismatches   = 0;
	int       quiet_cycles = 0;
	int       idle_pct     = 0;
	int       stall_pct    = 0;

	integer_matrix_multiply_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.elem_row   (elem_row),
		.elem_col   (elem_col),
		.elem_value (elem_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.prod_row   (prod_row),
		.prod_col   (prod_col),
		.prod_value (prod_value),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int clamp_dim(input logic [DIM_W-1:0] d);
		if (d == '0) return 1;
		if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
		return int'(d);
	endfunction

	function automatic logic signed [IN_VALUE_W-1:0] pick_value();
		case ($urandom_range(8))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return IN_VALUE_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return DIM_W'($urandom_range(1, 3));
		if (sel < 80) return '0;
		if (sel < 90) return DIM_W'($urandom_range(9, 15));
		return DIM_W'($urandom_range(4, 8));
	endfunction

	function automatic void predict_request(input logic [REQ_W-1:0] req,
			input logic [ROWCOL_W-1:0] row, input logic [ROWCOL_W-1:0] col,
			input logic signed [IN_VALUE_W-1:0] value);
		int       nr;
		int       nk;
		int       nc;
		int       acc;
		product_t p;
		case (req)
			REQ_LOAD_A: begin
				mat_a[row * MAX_DIM_DEF + col] = value;
				loaded_a[row * MAX_DIM_DEF + col] = 1'b1;
			end
			REQ_LOAD_B: begin
				mat_b[row * MAX_DIM_DEF + col] = value;
				loaded_b[row * MAX_DIM_DEF + col] = 1'b1;
			end
			REQ_START: begin
				nr = clamp_dim(dim_rows);
				nk = clamp_dim(dim_inner);
				nc = clamp_dim(dim_cols);
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = 0;
						for (int k = 0; k < nk; k++) begin
							acc += int'(mat_a[i * MAX_DIM_DEF + k]) *
								int'(mat_b[k * MAX_DIM_DEF + j]);
						end
						p.row   = ROWCOL_W'(i);
						p.col   = ROWCOL_W'(j);
						p.value = acc;
						p.last  = (i == nr - 1) && (j == nc - 1);
						pending_products.push_back(p);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [REQ_W-1:0] req, input logic [ROWCOL_W-1:0] row,
			input logic [ROWCOL_W-1:0] col, input logic signed [IN_VALUE_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		elem_row   <= row;
		elem_col   <= col;
		elem_value <= value;
		do @(posedge clk); while (in_stall);
		predict_request(req, row, col, value);
	endtask

	task automatic drain_products();
		in_valid <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
			input logic [DIM_W-1:0] cols, input bit poke_unused);
		logic [CFG_IDX_W-1:0] idx_list [4];
		logic [DIM_W-1:0]     data_list [4];
		int                   n_writes;
		idx_list  = '{CFG_ROWS_A, CFG_INNER_DIM, CFG_COLS_B, CFG_UNUSED};
		data_list = '{rows, inner, cols, DIM_W'($urandom)};
		n_writes  = poke_unused ? 4 : 3;
		drain_products();
		for (int w = 0; w < n_writes; w++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[w];
			cfg_data  <= data_list[w];
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[w])
				CFG_ROWS_A:    dim_rows  = data_list[w];
				CFG_INNER_DIM: dim_inner = data_list[w];
				CFG_COLS_B:    dim_cols  = data_list[w];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic start_multiply();
		int nr;
		int nk;
		int nc;
		nr = clamp_dim(dim_rows);
		nk = clamp_dim(dim_inner);
		nc = clamp_dim(dim_cols);
		for (int r = 0; r < nr; r++) begin
			for (int k = 0; k < nk; k++) begin
				if (!loaded_a[r * MAX_DIM_DEF + k]) begin
					send_item(REQ_LOAD_A, ROWCOL_W'(r), ROWCOL_W'(k), pick_value());
				end
			end
		end
		for (int k = 0; k < nk; k++) begin
			for (int c = 0; c < nc; c++) begin
				if (!loaded_b[k * MAX_DIM_DEF + c]) begin
					send_item(REQ_LOAD_B, ROWCOL_W'(k), ROWCOL_W'(c), pick_value());
				end
			end
		end
		send_item(REQ_START, ROWCOL_W'($urandom), ROWCOL_W'($urandom),
			IN_VALUE_W'($urandom));
	endtask

	task automatic test_reset_dims();
		idle_pct  = 0;
		stall_pct = 0;
		start_multiply();
	endtask

	task automatic test_corner_values();
		idle_pct  = 0;
		stall_pct = 0;
		set_dims(4'd1, 4'd1, 4'd1, 1'b0);
		send_item(REQ_LOAD_A, 3'd0, 3'd0, 16'sh8000);
		send_item(REQ_LOAD_B, 3'd0, 3'd0, 16'sh8000);
		start_multiply();
		send_item(REQ_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
		start_multiply();
		send_item(REQ_UNUSED, 3'd7, 3'd7, 16'sh7fff);
		set_dims(4'd0, 4'd0, 4'd0, 1'b1);
		start_multiply();
		set_dims(4'd15, 4'd15, 4'd15, 1'b0);
		start_multiply();
		for (int k = 0; k < MAX_DIM_DEF; k++) begin
			send_item(REQ_LOAD_A, 3'd0, ROWCOL_W'(k), 16'sh8000);
			send_item(REQ_LOAD_B, ROWCOL_W'(k), 3'd0,
				(k == MAX_DIM_DEF - 1) ? 16'sh0000 : 16'sh8000);
		end
		set_dims(4'd1, 4'd8, 4'd1, 1'b0);
		start_multiply();
		set_dims(4'd8, 4'd1, 4'd8, 1'b0);
		start_multiply();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int count);
		int sent;
		int sel;
		sent      = 0;
		idle_pct  = idle;
		stall_pct = stall;
		while (sent < count) begin
			set_dims(pick_dim(), pick_dim(), pick_dim(), $urandom_range(7) == 0);
			repeat ($urandom_range(4, 10)) begin
				sel = $urandom_range(99);
				if (sel < 60) begin
					send_item(sel < 30 ? REQ_LOAD_A : REQ_LOAD_B, ROWCOL_W'($urandom),
						ROWCOL_W'($urandom), pick_value());
					sent++;
				end else if (sel < 88) begin
					start_multiply();
					sent++;
				end else begin
					send_item(REQ_UNUSED, ROWCOL_W'($urandom), ROWCOL_W'($urandom),
						IN_VALUE_W'($urandom));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_products.size() == 0) begin
				report_mismatch($sformatf("unexpected product (%0d,%0d) value %0d last %0b",
					prod_row, prod_col, prod_value, last));
			end else begin
				head_product = pending_products.pop_front();
				if (prod_row !== head_product.row)
					report_mismatch($sformatf("prod_row %0d, want %0d",
						prod_row, head_product.row));
				if (prod_col !== head_product.col)
					report_mismatch($sformatf("prod_col %0d, want %0d",
						prod_col, head_product.col));
				if (prod_value !== head_product.value)
					report_mismatch($sformatf("prod_value %0d at (%0d,%0d), want %0d",
						prod_value, head_product.row, head_product.col,
						head_product.value));
				if (last !== head_product.last)
					report_mismatch($sformatf("last %0b at (%0d,%0d), want %0b",
						last, head_product.row, head_product.col, head_product.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == HANG_LIMIT) begin
			$display("tb_integer_matrix_multiply_core: errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_dims();
		test_corner_values();
		test_random_traffic(0, 0, 6);
		test_random_traffic(71, 0, 6);
		test_random_traffic(0, 71, 6);
		test_random_traffic(33, 33, 6);
		drain_products();
		repeat (20) @(posedge clk);
		if (pending_products.size() != 0) begin
			report_mismatch($sformatf("%0d product elements never arrived",
				pending_products.size()));
		end
		if (mismatches == 0) begin
			$display("tb_integer_matrix_multiply_core: clean");
		end else begin
			$display("tb_integer_matrix_multiply_core: errors");
		end
		$finish;
	end

endmodule
